// File: rtl/mrc4_pkg.sv
// package for the modified rc4 stream decryptor
// holds box geometry, the command kinds and the command record passed front to back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrc4_pkg;

  localparam int BOX_SIZE          = 256;
  localparam int BOX_AW            = 8;
  localparam int MAX_KEY_BYTES_DEF = 256;

  typedef enum logic [1:0] {
    CMD_KEY      = 2'd0,
    CMD_KEY_LAST = 2'd1,
    CMD_DATA     = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/mrc4_front.sv
// front end: accepts input transactions, classifies them and queues commands
// depends on mrc4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrc4_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [7:0]    s_axis_tdata,   // [7:0] byte_in
  input  wire logic          s_axis_tuser,   // [0] op
  input  wire logic          s_axis_tlast,
  output logic               cmd_valid,
  output mrc4_pkg::cmd_t     cmd,
  input  wire logic          cmd_pop
);
  import mrc4_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  cmd_t          queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  logic           pop;
  cmd_t           cmd_in;

  always_comb begin
    cmd_in.data = s_axis_tdata;
    if (s_axis_tuser) begin
      cmd_in.kind = CMD_DATA;
    end else if (s_axis_tlast) begin
      cmd_in.kind = CMD_KEY_LAST;
    end else begin
      cmd_in.kind = CMD_KEY;
    end
  end

  assign s_axis_tready = (count != (QAW+1)'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid     = (count != '0);
  assign pop           = cmd_pop && cmd_valid;
  assign cmd           = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/mrc4_back.sv
// back end: key store, permutation box, schedule sequencer and data decrypt
// holds the output register; depends on mrc4_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrc4_back #(
  parameter int MAX_KEY_BYTES = mrc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire mrc4_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] plain_byte
  output logic               m_axis_tuser    // [0] key_ready
);
  import mrc4_pkg::*;

  localparam int KCW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SW_RD,
    ST_SW_C,
    ST_SW_WI,
    ST_SW_WC,
    ST_D_J,
    ST_D_IN,
    ST_D_KS,
    ST_D_XOR,
    ST_D_OUT
  } state_t;

  state_t            state;

  // memories
  logic [7:0]        box_mem [BOX_SIZE];
  logic [7:0]        key_mem [MAX_KEY_BYTES];
  logic              box_we;
  logic [BOX_AW-1:0] box_waddr;
  logic [7:0]        box_wdata;
  logic [BOX_AW-1:0] box_raddr;
  logic [7:0]        box_rdata;
  logic              key_we;
  logic [KAW-1:0]    key_raddr;
  logic [7:0]        key_rdata;

  // control and datapath registers
  logic [KCW-1:0]    key_count;
  logic [KCW-1:0]    key_len;
  logic [KCW-1:0]    koff;
  logic [BOX_AW-1:0] idx;
  logic [BOX_AW-1:0] prev;
  logic [BOX_AW-1:0] c_reg;
  logic [7:0]        held;
  logic [7:0]        bj;
  logic [7:0]        cur_byte;
  logic [BOX_AW-1:0] stream_pos;
  logic              schedule_done;
  logic              out_valid;
  logic [7:0]        out_data;
  logic              out_user;

  logic              out_free;
  logic              key_room;
  logic [KCW-1:0]    cnt_new;
  logic [KCW-1:0]    koff_inc;
  logic [BOX_AW-1:0] j_pos;
  logic [BOX_AW-1:0] c_calc;

  assign out_free = !out_valid || m_axis_tready;
  assign key_room = (key_count < KCW'(MAX_KEY_BYTES));
  assign cnt_new  = key_count + KCW'(key_room);
  assign koff_inc = koff + KCW'(1);
  assign j_pos    = stream_pos + BOX_AW'(1);
  assign c_calc   = box_rdata + prev + key_rdata;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign key_we   = cmd_pop && (cmd.kind != CMD_DATA) && key_room;
  assign key_raddr = koff[KAW-1:0];

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

  // box port control
  always_comb begin
    box_we    = 1'b0;
    box_waddr = idx;
    box_wdata = idx;
    box_raddr = idx;
    unique case (state)
      ST_FILL: begin
        box_we = 1'b1;
      end
      ST_SW_C: begin
        box_raddr = c_calc;
      end
      ST_SW_WI: begin
        box_we    = 1'b1;
        box_wdata = box_rdata;
      end
      ST_SW_WC: begin
        box_we    = 1'b1;
        box_waddr = c_reg;
        box_wdata = held;
      end
      ST_D_J: begin
        box_raddr = j_pos;
      end
      ST_D_IN: begin
        box_raddr = box_rdata + j_pos;
      end
      ST_D_KS: begin
        box_raddr = bj + box_rdata;
      end
      default: begin
        box_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[box_waddr] <= box_wdata;
    end
    box_rdata <= box_mem[box_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KAW-1:0]] <= cmd.data;
    end
    key_rdata <= key_mem[key_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      key_count     <= '0;
      stream_pos    <= '0;
      schedule_done <= 1'b0;
      out_valid     <= 1'b0;
      idx           <= '0;
      koff          <= '0;
      prev          <= '0;
    end else begin
      // in ST_D_OUT the register is refilled in the same cycle it drains
      if (out_valid && m_axis_tready && (state != ST_D_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              CMD_KEY: begin
                key_count <= cnt_new;
              end
              CMD_KEY_LAST: begin
                key_count <= '0;
                key_len   <= (cnt_new == '0) ? KCW'(1) : cnt_new;
                idx       <= '0;
                koff      <= '0;
                prev      <= '0;
                state     <= ST_FILL;
              end
              CMD_DATA: begin
                cur_byte <= cmd.data;
                state    <= schedule_done ? ST_D_J : ST_D_OUT;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_FILL: begin
          idx <= idx + BOX_AW'(1);
          if (idx == BOX_AW'(BOX_SIZE - 1)) begin
            state <= ST_SW_RD;
          end
        end
        ST_SW_RD: begin
          state <= ST_SW_C;
        end
        ST_SW_C: begin
          held  <= box_rdata;
          c_reg <= c_calc;
          state <= ST_SW_WI;
        end
        ST_SW_WI: begin
          state <= ST_SW_WC;
        end
        ST_SW_WC: begin
          prev <= c_reg;
          koff <= (koff_inc >= key_len) ? '0 : koff_inc;
          idx  <= idx + BOX_AW'(1);
          if (idx == BOX_AW'(BOX_SIZE - 1)) begin
            schedule_done <= 1'b1;
            stream_pos    <= '0;
            state         <= ST_IDLE;
          end else begin
            state <= ST_SW_RD;
          end
        end
        ST_D_J: begin
          state <= ST_D_IN;
        end
        ST_D_IN: begin
          bj    <= box_rdata;
          state <= ST_D_KS;
        end
        ST_D_KS: begin
          state <= ST_D_XOR;
        end
        ST_D_XOR: begin
          cur_byte <= cur_byte ^ box_rdata;
          state    <= ST_D_OUT;
        end
        ST_D_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= cur_byte;
            out_user  <= schedule_done;
            if (schedule_done) begin
              stream_pos <= j_pos;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/modified_rc4_stream_decrypt.sv
// top level of the modified rc4 stream decryptor
// instantiates mrc4_front and mrc4_back; depends on mrc4_pkg
//
// input stream: tdata carries a key or cipher byte, tuser is 0 for a key byte and
// 1 for a data byte, tlast on a key byte marks the final key byte.
// output stream: one transaction per data byte; tdata is the plain byte, tuser
// is 1 once a key schedule has completed (before that data passes unchanged).
// key bytes produce no output transaction.
// a four-entry command queue decouples the input from the sequencer, so input
// transactions keep being taken while the back end works or the output stalls,
// until the queue is full. a key byte is handled in the idle state; a data byte
// after a schedule passes ST_D_J, ST_D_IN, ST_D_KS, ST_D_XOR and ST_D_OUT, and
// before one goes straight to ST_D_OUT; the single-read-port box memory sets
// these steps (three dependent box reads per keystream byte). a final key byte
// runs the schedule: an identity fill of the 256 box entries, then one swap step
// per entry through ST_SW_RD, ST_SW_C, ST_SW_WI and ST_SW_WC; queued items wait.
// when the receiver stalls, the output register holds and the back end waits.
// synchronous reset clears the queue, counters and the schedule flag; the box
// and key memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module modified_rc4_stream_decrypt #(
  parameter int MAX_KEY_BYTES = mrc4_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_in
  input  wire logic       s_axis_tuser,   // [0] op
  input  wire logic       s_axis_tlast,   // last_key
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] plain_byte
  output logic            m_axis_tuser    // [0] key_ready
);
  import mrc4_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mrc4_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  mrc4_back #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: dv/tb_modified_rc4_stream_decrypt.sv
// self-checking testbench for modified_rc4_stream_decrypt, key schedule and keystream xor
// a local predictor of the box and stream position checks every output transaction
// depends on mrc4_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_modified_rc4_stream_decrypt;
  import mrc4_pkg::*;

  localparam bit OP_KEY  = 1'b0;
  localparam bit OP_DATA = 1'b1;
  localparam int KEY_CAP = MAX_KEY_BYTES_DEF;
  localparam int RANDOM_ITEMS = 320;
  localparam int DRAIN_CYCLES = 1600;
  localparam int LIMIT_CYCLES = 1000000;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] byte_in
  logic       s_axis_tuser = 1'b0;    // [0] op
  logic       s_axis_tlast = 1'b0;    // last_key
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] plain_byte
  logic       m_axis_tuser;           // [0] key_ready

  modified_rc4_stream_decrypt dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  typedef struct packed {
    logic [7:0] plain;
    logic       ready;
  } plain_rec_t;

  // predictor state
  logic [7:0] rc4_box [0:BOX_SIZE-1];
  logic [7:0] key_bytes [0:BOX_SIZE-1];
  logic [8:0] key_len = '0;
  logic [7:0] pos = '0;
  bit         scheduled = 1'b0;
  plain_rec_t pending_plain [$];

  int  err_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  int  stall_req = 0;
  int  hold_left = 0;
  plain_rec_t want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void run_key_schedule(int unsigned len);
    logic [7:0] held, c, prev;
    int unsigned koff;
    int i;
    for (i = 0; i < BOX_SIZE; i++) rc4_box[i] = i[7:0];
    prev = '0;
    koff = 0;
    for (i = 0; i < BOX_SIZE; i++) begin
      held = rc4_box[i];
      c = held + prev + key_bytes[koff[7:0]];
      koff++;
      if (koff >= len) koff = 0;
      rc4_box[i] = rc4_box[c];
      rc4_box[c] = held;
      prev = c;
    end
  endfunction

  function automatic void predict_item(bit op, logic [7:0] b, bit last);
    logic [7:0] j, bj, inner, idx, ks;
    plain_rec_t rec;
    if (op == OP_KEY) begin
      // a full store drops the byte, but the final flag still runs the schedule
      if (key_len < KEY_CAP) begin
        key_bytes[key_len[7:0]] = b;
        key_len++;
      end
      if (last) begin
        run_key_schedule((key_len == 0) ? 1 : key_len);
        key_len = '0;
        pos = '0;
        scheduled = 1'b1;
      end
    end else if (!scheduled) begin
      rec.plain = b;
      rec.ready = 1'b0;
      pending_plain.push_back(rec);
    end else begin
      j = pos + 8'd1;
      bj = rc4_box[j];
      idx = bj + j;
      inner = rc4_box[idx];
      idx = bj + inner;
      ks = rc4_box[idx];
      rec.plain = b ^ ks;
      rec.ready = 1'b1;
      pending_plain.push_back(rec);
      pos = pos + 8'd1;
    end
  endfunction

  task automatic send_item(bit op, logic [7:0] b, bit last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_item(op, b, last);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < 26) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
  endtask

  // output side: checks each transaction, then picks tready for the next cycle
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_plain.size() == 0) begin
        $error("unexpected result plain_byte=%h key_ready=%b", m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = pending_plain.pop_front();
        if (m_axis_tdata !== want.plain) begin
          $error("plain_byte expected %h actual %h", want.plain, m_axis_tdata);
          err_count++;
        end
        if (m_axis_tuser !== want.ready) begin
          $error("key_ready expected %b actual %b", want.ready, m_axis_tuser);
          err_count++;
        end
      end
    end
    if (stall_req != 0) begin
      hold_left = stall_req;
      stall_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (calm) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= 26);
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // data before any schedule passes through, even with key bytes in between
  task automatic test_passthrough_before_key();
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hff, 1'b1);
    send_item(OP_KEY,  8'h00, 1'b0);
    send_item(OP_DATA, 8'h5a, 1'b0);
    send_item(OP_KEY,  8'hff, 1'b0);
    send_item(OP_DATA, 8'ha5, 1'b1);
  endtask

  // first schedule, a one-byte key, and data using the old box while a new key builds
  task automatic test_first_schedule();
    send_item(OP_KEY,  8'h80, 1'b1);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hff, 1'b0);
    send_item(OP_DATA, 8'h01, 1'b1);
    send_item(OP_KEY,  8'h7e, 1'b1);
    send_item(OP_DATA, 8'hff, 1'b0);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_KEY,  8'h11, 1'b0);
    send_item(OP_DATA, 8'h3c, 1'b0);
    send_item(OP_KEY,  8'h22, 1'b0);
    send_item(OP_DATA, 8'hc3, 1'b1);
    send_item(OP_KEY,  8'h33, 1'b1);
    send_item(OP_DATA, 8'h00, 1'b0);
    send_item(OP_DATA, 8'hff, 1'b0);
  endtask

  // a full key store drops extra bytes; also a key of exactly the maximum length
  task automatic test_key_store_full();
    int k;
    for (k = 0; k < KEY_CAP; k++) send_item(OP_KEY, 8'($urandom), 1'b0);
    send_item(OP_KEY, 8'hff, 1'b1);
    for (k = 0; k < 8; k++) send_item(OP_DATA, 8'($urandom), 1'b0);
    for (k = 0; k < KEY_CAP; k++) send_item(OP_KEY, 8'($urandom), k == KEY_CAP - 1);
    for (k = 0; k < 8; k++) send_item(OP_DATA, 8'($urandom), 1'b0);
  endtask

  // stream position wraps past 255
  task automatic test_stream_wrap();
    int k;
    send_item(OP_KEY, 8'($urandom), 1'b0);
    send_item(OP_KEY, 8'($urandom), 1'b1);
    for (k = 0; k < 300; k++) send_item(OP_DATA, 8'($urandom), 1'($urandom));
  endtask

  // receiver holds off long enough for the input to stall, then sender drains
  task automatic test_output_backpressure();
    int k;
    calm = 1'b1;
    stall_req = 400;
    for (k = 0; k < 30; k++) send_item(OP_DATA, 8'($urandom), 1'b0);
    wait_all_results();
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int seq, n, k, klen, r, start;
    seq = 0;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      calm = (seq >= 2 && seq < 5);
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 70) klen = $urandom_range(1, 16);
        else if (r < 96) klen = $urandom_range(17, 64);
        else klen = $urandom_range(250, 257);
        for (k = 0; k < klen; k++) send_item(OP_KEY, 8'($urandom), k == klen - 1);
        n = $urandom_range(4, 40);
        for (k = 0; k < n; k++) begin
          send_item(OP_DATA, 8'($urandom), 1'($urandom));
          // stray key bytes start the next key while the old box stays in use
          if ($urandom_range(0, 49) == 0) send_item(OP_KEY, 8'($urandom), 1'b0);
        end
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
          send_item(1'($urandom), 8'($urandom), $urandom_range(0, 9) == 0);
      end
      seq++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_passthrough_before_key();
    test_first_schedule();
    test_key_store_full();
    test_stream_wrap();
    test_output_backpressure();
    test_random_traffic();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_plain.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
